### sv/mndq_pkg.sv
// shared types and constants for the midi note-off delay queue
// no dependencies; imported by the slot cell and the top level
package mndq_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);

   // register indexes of the control port
   localparam logic CSR_DELAY = 1'b0;
   localparam logic CSR_PEDAL = 1'b1;

   // midi codes
   localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
   localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
   localparam logic [1:0] FULL_COUNT    = 2'd3;

   typedef struct packed {
      logic        mode;
      logic [15:0] time_offset;
      logic [7:0]  status_byte;
      logic [7:0]  data_one;
      logic [7:0]  data_two;
      logic [1:0]  byte_count;
      logic [15:0] period_length;
   } req_word_type;

   typedef struct packed {
      logic [15:0] out_time;
      logic [7:0]  out_status;
      logic [7:0]  out_data_one;
      logic [7:0]  out_data_two;
      logic [1:0]  out_count;
      logic        last_of_run;
   } rsp_word_type;

   // one held note-off
   typedef struct packed {
      logic        valid;
      logic [23:0] bytes;
      logic [25:0] due;
   } slot_type;

   typedef enum logic [1:0] {
      OP_NOTE_ON,
      OP_NOTE_OFF,
      OP_FORWARD,
      OP_PERIOD
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND,
      ST_WRITE,
      ST_EMIT_OFF,
      ST_EMIT_MSG,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   // ring pointer step with wrap at the queue depth
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

endpackage

### sv/midi_note_off_delay_queue.sv
// top level of the midi note-off delay queue: control, ring of slot cells, output stage
// depends on mndq_pkg and mndq_cell
//
//   channel | ports                       | direction | word
//   request | req_valid req_ready req_data | in        | req_word_type
//   result  | rsp_valid rsp_ready rsp_data | out       | rsp_word_type
//   control | csr_valid csr_ready csr_index csr_data | in | index, 24-bit data
//
// The held slots form a ring of cells that rotates by one slot at a time during a scan;
// the slot at the head is the only one examined. A scan first rotates the wanted slot to
// the head, then visits up to QUEUE_DEPTH slots one a cycle, save where a stall holds it.
// An item keeps the control busy through these ring rotations; the next word is taken only
// once the control is back in its idle state.
// Synchronous reset empties the queue at once. A stalled result side stops the scan
// only at a slot that has to emit; one finished word waits in the output register.
module midi_note_off_delay_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mndq_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mndq_pkg::rsp_word_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [23:0]            csr_data
);
   import mndq_pkg::*;

   // configuration registers
   logic [23:0] delay_ff;
   logic        pedal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
         pedal_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DELAY: delay_ff <= csr_data;
            CSR_PEDAL: pedal_ff <= csr_data[0];
            default:   delay_ff <= delay_ff;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // control state
   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   req_word_type     item_ff, item_in;
   logic [16:0]      limit_ff, limit_in;
   logic             period_ff, period_in;
   logic             skipped_ff, skipped_in;
   logic             found_ff, found_in;
   logic [PTR_W-1:0] scan_ff, scan_in;
   logic [PTR_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic             hold_valid_ff, hold_valid_in;
   rsp_word_type     hold_ff, hold_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_ff, rsp_in;

   // ring of cells, head is cell 0
   slot_type cell_q [QUEUE_DEPTH];
   slot_type cell_d [QUEUE_DEPTH];
   slot_type head, head_mod;
   logic     rotate;

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_ring
      if (g == QUEUE_DEPTH - 1) begin : g_tail
         assign cell_d[g] = head_mod;
      end else begin : g_body
         assign cell_d[g] = cell_q[g+1];
      end
      mndq_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .shift  (rotate),
         .slot_d (cell_d[g]),
         .slot_q (cell_q[g])
      );
   end
   assign head = cell_q[0];

   // shared conditions
   logic         at_slot, last_visit, key_match, is_due, out_free, can_push;
   logic [25:0]  renew_due;
   logic [3:0]   item_kind;
   logic         item_off;
   op_type       new_op;
   logic         req_fire;

   always_comb begin
      at_slot    = (head_ff == scan_ff);
      last_visit = (scan_ff == wp_ff) || (count_ff == PTR_W'(QUEUE_DEPTH - 1));
      key_match  = head.valid && (head.bytes[3:0] == item_ff.status_byte[3:0])
                   && (head.bytes[14:8] == item_ff.data_one[6:0]);
      is_due     = head.due < {9'd0, limit_ff};
      renew_due  = {10'd0, item_ff.time_offset} + {2'd0, delay_ff};
      out_free   = !rsp_valid_ff || rsp_ready;
      can_push   = !hold_valid_ff || out_free;
      req_fire   = req_valid && req_ready;
      // decode the incoming word
      item_kind  = req_data.status_byte[7:4];
      item_off   = (item_kind == KIND_NOTE_OFF)
                   || (item_kind == KIND_NOTE_ON && req_data.data_two[6:0] == 7'd0);
      if (req_data.mode) begin
         new_op = OP_PERIOD;
      end else if (req_data.byte_count == FULL_COUNT && pedal_ff && item_off) begin
         new_op = OP_NOTE_OFF;
      end else if (req_data.byte_count == FULL_COUNT && pedal_ff
                   && item_kind == KIND_NOTE_ON) begin
         new_op = OP_NOTE_ON;
      end else begin
         new_op = OP_FORWARD;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (new_op)
                  OP_PERIOD:   state_in = ST_FLUSH;
                  OP_FORWARD:  state_in = ST_EMIT_MSG;
                  default:     state_in = ST_FIND;
               endcase
            end
         end
         ST_FIND: begin
            if (at_slot) begin
               if (key_match) begin
                  state_in = (op_ff == OP_NOTE_OFF) ? ST_FLUSH : ST_EMIT_OFF;
               end else if (last_visit) begin
                  state_in = (op_ff == OP_NOTE_OFF) ? ST_WRITE : ST_EMIT_MSG;
               end
            end
         end
         ST_WRITE: begin
            if (at_slot) begin
               state_in = ST_FLUSH;
            end
         end
         ST_EMIT_OFF: begin
            if (can_push) begin
               state_in = ST_EMIT_MSG;
            end
         end
         ST_EMIT_MSG: begin
            if (can_push) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (at_slot && last_visit && (!(head.valid && is_due) || can_push)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!hold_valid_ff || out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   logic         emit_req, emit_fire, finish_fire;
   rsp_word_type emit_word;

   always_comb begin
      op_in      = op_ff;
      item_in    = item_ff;
      limit_in   = limit_ff;
      period_in  = period_ff;
      skipped_in = skipped_ff;
      found_in   = found_ff;
      scan_in    = scan_ff;
      count_in   = count_ff;
      rp_in      = rp_ff;
      wp_in      = wp_ff;
      rotate     = 1'b0;
      head_mod   = head;
      emit_req   = 1'b0;
      emit_word  = '0;
      finish_fire = 1'b0;
      req_ready  = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               item_in    = req_data;
               op_in      = new_op;
               scan_in    = rp_ff;
               count_in   = '0;
               found_in   = 1'b0;
               skipped_in = 1'b0;
               period_in  = req_data.mode;
               limit_in   = {1'b0, req_data.period_length};
            end
         end
         ST_FIND: begin
            rotate = 1'b1;
            if (at_slot) begin
               if (key_match) begin
                  found_in = 1'b1;
                  if (op_ff == OP_NOTE_OFF) begin
                     head_mod.due = renew_due;
                  end else begin
                     head_mod.valid = 1'b0;
                  end
               end else begin
                  scan_in  = ptr_next(scan_ff);
                  count_in = count_ff + 1'b1;
               end
               if (key_match || last_visit) begin
                  // next scan: the write slot or the flush start
                  scan_in  = (op_ff == OP_NOTE_OFF && !key_match) ? wp_ff : rp_ff;
                  count_in = '0;
                  limit_in = {1'b0, item_ff.time_offset} + 17'd1;
               end
            end
         end
         ST_WRITE: begin
            rotate = 1'b1;
            if (at_slot) begin
               head_mod = '{valid: 1'b1,
                            bytes: {item_ff.data_two, item_ff.data_one, item_ff.status_byte},
                            due:   renew_due};
               wp_in    = ptr_next(wp_ff);
               scan_in  = rp_ff;
               count_in = '0;
            end
         end
         ST_EMIT_OFF: begin
            emit_req  = found_ff;
            emit_word = '{out_time:     item_ff.time_offset,
                          out_status:   {KIND_NOTE_OFF, item_ff.status_byte[3:0]},
                          out_data_one: {1'b0, item_ff.data_one[6:0]},
                          out_data_two: 8'd0,
                          out_count:    FULL_COUNT,
                          last_of_run:  1'b0};
         end
         ST_EMIT_MSG: begin
            emit_req  = 1'b1;
            emit_word = '{out_time:     item_ff.time_offset,
                          out_status:   item_ff.status_byte,
                          out_data_one: (item_ff.byte_count >= 2'd2) ? item_ff.data_one : 8'd0,
                          out_data_two: (item_ff.byte_count == FULL_COUNT)
                                        ? item_ff.data_two : 8'd0,
                          out_count:    item_ff.byte_count,
                          last_of_run:  1'b0};
            scan_in   = rp_ff;
            count_in  = '0;
            limit_in  = {1'b0, item_ff.time_offset} + 17'd1;
         end
         ST_FLUSH: begin
            if (!at_slot) begin
               rotate = 1'b1;
            end else if (head.valid && is_due) begin
               emit_req  = 1'b1;
               emit_word = '{out_time:     head.due[15:0],
                             out_status:   head.bytes[7:0],
                             out_data_one: head.bytes[15:8],
                             out_data_two: head.bytes[23:16],
                             out_count:    FULL_COUNT,
                             last_of_run:  1'b0};
               if (can_push) begin
                  rotate         = 1'b1;
                  head_mod.valid = 1'b0;
                  if (!skipped_ff) begin
                     rp_in = ptr_next(rp_ff);
                  end
               end
            end else begin
               rotate = 1'b1;
               if (head.valid) begin
                  skipped_in = 1'b1;
                  if (period_ff) begin
                     head_mod.due = head.due - {9'd0, limit_ff};
                  end
               end else if (!skipped_ff) begin
                  rp_in = scan_ff;
               end
            end
            if (rotate && at_slot) begin
               scan_in  = ptr_next(scan_ff);
               count_in = count_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            finish_fire = !hold_valid_ff || out_free;
         end
         default: begin
            rotate = 1'b0;
         end
      endcase
      emit_fire = emit_req && can_push;
   end

   // result staging: one word held back until the next decides its last flag
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      if (emit_fire) begin
         if (hold_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = hold_ff;
         end
         hold_valid_in = 1'b1;
         hold_in       = emit_word;
      end else if (finish_fire && hold_valid_ff) begin
         rsp_valid_in        = 1'b1;
         rsp_in              = hold_ff;
         rsp_in.last_of_run  = 1'b1;
         hold_valid_in       = 1'b0;
      end
   end

   assign head_in = rotate ? ptr_next(head_ff) : head_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         rp_ff         <= '0;
         wp_ff         <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         rp_ff         <= rp_in;
         wp_ff         <= wp_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // item and scan registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      item_ff    <= item_in;
      limit_ff   <= limit_in;
      period_ff  <= period_in;
      skipped_ff <= skipped_in;
      found_ff   <= found_in;
      scan_ff    <= scan_in;
      count_ff   <= count_in;
      hold_ff    <= hold_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // nothing may be left staged between items
   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !hold_valid_ff)
      else $error("staged result left over at idle");

   // the output register is only loaded when it is free
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (emit_fire && hold_valid_ff) || (finish_fire && hold_valid_ff) |-> out_free)
      else $error("result overwritten in output register");

   // an accepted word always starts work
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("accepted word dropped");

   // a word marked last only leaves in the finishing step
   a_last_at_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_in && rsp_in.last_of_run && !(rsp_valid_ff && !rsp_ready)
      |-> state_ff == ST_FINISH)
      else $error("last flag outside finish");

endmodule

### sv/mndq_cell.sv
// one slot of the rotating ring of held note-offs
// depends on mndq_pkg
module mndq_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  mndq_pkg::slot_type slot_d,
   output mndq_pkg::slot_type slot_q
);
   import mndq_pkg::*;

   logic        valid_ff;
   logic [23:0] bytes_ff;
   logic [25:0] due_ff;

   // valid bit clears on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= slot_d.valid;
      end
   end

   // payload moves with the ring
   always_ff @(posedge clock) begin
      if (shift) begin
         bytes_ff <= slot_d.bytes;
         due_ff   <= slot_d.due;
      end
   end

   assign slot_q = '{valid: valid_ff, bytes: bytes_ff, due: due_ff};

endmodule
